>>> src/msrs_pkg.sv
// Shared types, constants and codes for the motor speed ramp sequencer.
package msrs_pkg;

   localparam int FREQ_BITS   = 20;
   localparam int RPM_W       = 16;
   localparam int ERR_W       = 8;
   localparam int STEP_W      = 16;
   localparam int RATE_W      = 24;
   localparam int RATE_FRAC   = 16;
   localparam int PROD_W      = RPM_W + RATE_W;
   localparam int CALC_W      = PROD_W + 1 - RATE_FRAC;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int STATUS_W    = 3;
   localparam int REPLY_W     = 2;
   localparam int MODE_W      = 2;

   localparam logic [FREQ_BITS-1:0] MIN_FREQ_RST  = FREQ_BITS'(100);
   localparam logic [FREQ_BITS-1:0] MAX_FREQ_RST  = FREQ_BITS'(20000);
   localparam logic [RPM_W-1:0]     MIN_RPM_RST   = RPM_W'(100);
   localparam logic [RPM_W-1:0]     MAX_RPM_RST   = RPM_W'(6000);
   localparam logic [STEP_W-1:0]    STEP_RST      = STEP_W'(100);
   localparam logic [RATE_W-1:0]    RATE_RST      = RATE_W'(65536);
   localparam logic [PROD_W:0]      ROUND_HALF    = (PROD_W+1)'(1) << (RATE_FRAC - 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_SPEED = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_FREQ = 3'd0,
      CSR_MAX_FREQ = 3'd1,
      CSR_MIN_RPM  = 3'd2,
      CSR_MAX_RPM  = 3'd3,
      CSR_STEP     = 3'd4,
      CSR_RATE     = 3'd5
   } csr_index_type;

   localparam logic [REPLY_W-1:0] REPLY_OK        = 2'd0;
   localparam logic [REPLY_W-1:0] REPLY_BAD_STATE = 2'd1;
   localparam logic [REPLY_W-1:0] REPLY_BAD_ARG   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_STARTING = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RUNNING  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RAMPING  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_STOPPING = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FAULT    = 3'd5;

   typedef enum logic [5:0] {
      PH_DISABLED = 6'b000001,
      PH_STARTING = 6'b000010,
      PH_RUNNING  = 6'b000100,
      PH_RAMPING  = 6'b001000,
      PH_STOPPING = 6'b010000,
      PH_FAULT    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [FREQ_BITS-1:0] min_freq;
      logic [FREQ_BITS-1:0] max_freq;
      logic [RPM_W-1:0]     min_rpm;
      logic [RPM_W-1:0]     max_rpm;
      logic [STEP_W-1:0]    ramp_step;
      logic [RATE_W-1:0]    rpm_rate;
   } cfg_type;

   typedef struct packed {
      mode_type           mode;
      logic [RPM_W-1:0]   speed_rpm;
      logic [ERR_W-1:0]   driver_error;
      logic [CALC_W-1:0]  calc_freq;
   } item_type;

   typedef struct packed {
      logic [REPLY_W-1:0]   reply;
      logic [STATUS_W-1:0]  status;
      logic [FREQ_BITS-1:0] current_frequency;
      logic [FREQ_BITS-1:0] target_frequency;
      logic                 frequency_written;
      logic                 pulse_enabled;
      logic                 drive_enabled;
      logic [ERR_W-1:0]     last_fault;
   } result_type;

   function automatic logic [STATUS_W-1:0] phase_code(phase_type ph);
      logic [STATUS_W-1:0] code;
      unique case (ph)
         PH_DISABLED: code = ST_DISABLED;
         PH_STARTING: code = ST_STARTING;
         PH_RUNNING:  code = ST_RUNNING;
         PH_RAMPING:  code = ST_RAMPING;
         PH_STOPPING: code = ST_STOPPING;
         PH_FAULT:    code = ST_FAULT;
         default:     code = ST_DISABLED;
      endcase
      return code;
   endfunction

endpackage

>>> src/msrs_if.sv
// Valid/ready channel interfaces for command items and result items.
interface msrs_req_if
   import msrs_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [RPM_W-1:0]   speed_rpm;
   logic [ERR_W-1:0]   driver_error;

   modport source (output valid, mode, speed_rpm, driver_error, input ready);
   modport sink   (input valid, mode, speed_rpm, driver_error, output ready);
endinterface

interface msrs_rsp_if
   import msrs_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [REPLY_W-1:0]   reply;
   logic [STATUS_W-1:0]  status;
   logic [FREQ_BITS-1:0] current_frequency;
   logic [FREQ_BITS-1:0] target_frequency;
   logic                 frequency_written;
   logic                 pulse_enabled;
   logic                 drive_enabled;
   logic [ERR_W-1:0]     last_fault;

   modport source (output valid, reply, status, current_frequency, target_frequency,
                   frequency_written, pulse_enabled, drive_enabled, last_fault,
                   input ready);
   modport sink   (input valid, reply, status, current_frequency, target_frequency,
                   frequency_written, pulse_enabled, drive_enabled, last_fault,
                   output ready);
endinterface

>>> src/msrs_cfg.sv
// Configuration register file with its write decoder.
module msrs_cfg
   import msrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_FREQ: cfg_in.min_freq  = csr_wdata[FREQ_BITS-1:0];
            CSR_MAX_FREQ: cfg_in.max_freq  = csr_wdata[FREQ_BITS-1:0];
            CSR_MIN_RPM:  cfg_in.min_rpm   = csr_wdata[RPM_W-1:0];
            CSR_MAX_RPM:  cfg_in.max_rpm   = csr_wdata[RPM_W-1:0];
            CSR_STEP:     cfg_in.ramp_step = csr_wdata[STEP_W-1:0];
            CSR_RATE:     cfg_in.rpm_rate  = csr_wdata[RATE_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_freq  <= MIN_FREQ_RST;
         cfg_ff.max_freq  <= MAX_FREQ_RST;
         cfg_ff.min_rpm   <= MIN_RPM_RST;
         cfg_ff.max_rpm   <= MAX_RPM_RST;
         cfg_ff.ramp_step <= STEP_RST;
         cfg_ff.rpm_rate  <= RATE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/msrs_core.sv
// Sequencer state and the single-pass update for one command or tick.
module msrs_core
   import msrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   phase_type            phase_ff, phase_in;
   logic [FREQ_BITS-1:0] now_ff, now_in;
   logic [FREQ_BITS-1:0] goal_ff, goal_in;
   logic                 pulse_ff, pulse_in;
   logic                 drive_ff, drive_in;
   logic [ERR_W-1:0]     fault_ff, fault_in;

   logic [STEP_W-1:0]    step;
   logic                 up, at_goal, err;
   logic [FREQ_BITS-1:0] span, move, next_freq;
   logic [REPLY_W-1:0]   reply;
   logic                 wrote;

   // one ramp step toward the goal
   always_comb begin
      step    = (cfg.ramp_step == '0) ? STEP_W'(1) : cfg.ramp_step;
      up      = now_ff < goal_ff;
      at_goal = now_ff == goal_ff;
      span    = up ? goal_ff - now_ff : now_ff - goal_ff;
      move    = (span < FREQ_BITS'(step)) ? span : FREQ_BITS'(step);
      next_freq = up ? now_ff + move : now_ff - move;
      err     = item.driver_error != '0;
   end

   always_comb begin
      phase_in = phase_ff;
      now_in   = now_ff;
      goal_in  = goal_ff;
      pulse_in = pulse_ff;
      drive_in = drive_ff;
      fault_in = fault_ff;
      reply    = REPLY_OK;
      wrote    = 1'b0;

      case (item.mode)
         MODE_TICK: begin
            unique case (phase_ff)
               PH_STARTING: begin
                  if (err) begin
                     phase_in = PH_FAULT;
                  end else begin
                     now_in   = cfg.min_freq;
                     pulse_in = 1'b1;
                     drive_in = 1'b1;
                     wrote    = 1'b1;
                     phase_in = (goal_ff > cfg.min_freq) ? PH_RAMPING : PH_RUNNING;
                  end
               end
               PH_STOPPING: begin
                  if (!drive_ff && !pulse_ff) begin
                     now_in   = '0;
                     goal_in  = cfg.min_freq;
                     phase_in = PH_DISABLED;
                  end else if (err) begin
                     phase_in = PH_FAULT;
                  end else if (!at_goal) begin
                     now_in = next_freq;
                     wrote  = 1'b1;
                  end else begin
                     pulse_in = 1'b0;
                     drive_in = 1'b0;
                     now_in   = '0;
                     goal_in  = cfg.min_freq;
                     phase_in = PH_DISABLED;
                  end
               end
               PH_RUNNING, PH_RAMPING: begin
                  if (at_goal) begin
                     phase_in = PH_RUNNING;
                  end else if (err) begin
                     phase_in = PH_FAULT;
                  end else begin
                     now_in   = next_freq;
                     wrote    = 1'b1;
                     phase_in = (next_freq == goal_ff) ? PH_RUNNING : PH_RAMPING;
                  end
               end
               default: begin
               end
            endcase
            if (phase_in == PH_FAULT && phase_ff != PH_FAULT) begin
               pulse_in = 1'b0;
               drive_in = 1'b0;
               fault_in = item.driver_error;
            end
         end
         MODE_START: begin
            if (phase_ff == PH_DISABLED) begin
               phase_in = PH_STARTING;
            end else if (phase_ff == PH_STOPPING || phase_ff == PH_FAULT) begin
               reply = REPLY_BAD_STATE;
            end
         end
         MODE_STOP: begin
            if (phase_ff == PH_FAULT) begin
               reply = REPLY_BAD_STATE;
            end else if (phase_ff != PH_DISABLED && phase_ff != PH_STOPPING) begin
               goal_in  = cfg.min_freq;
               phase_in = PH_STOPPING;
            end
         end
         default: begin
            if (phase_ff == PH_STOPPING || phase_ff == PH_FAULT) begin
               reply = REPLY_BAD_STATE;
            end else if (item.speed_rpm < cfg.min_rpm || item.speed_rpm > cfg.max_rpm) begin
               reply = REPLY_BAD_ARG;
            end else if (item.calc_freq < CALC_W'(cfg.min_freq) ||
                         item.calc_freq > CALC_W'(cfg.max_freq)) begin
               reply = REPLY_BAD_ARG;
            end else begin
               goal_in = item.calc_freq[FREQ_BITS-1:0];
               if (phase_ff == PH_RUNNING) begin
                  phase_in = PH_RAMPING;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DISABLED;
         now_ff   <= '0;
         goal_ff  <= MIN_FREQ_RST;
         pulse_ff <= 1'b0;
         drive_ff <= 1'b0;
         fault_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         now_ff   <= now_in;
         goal_ff  <= goal_in;
         pulse_ff <= pulse_in;
         drive_ff <= drive_in;
         fault_ff <= fault_in;
      end
   end

   always_comb begin
      result.reply             = reply;
      result.status            = phase_code(phase_in);
      result.current_frequency = now_in;
      result.target_frequency  = goal_in;
      result.frequency_written = wrote;
      result.pulse_enabled     = pulse_in;
      result.drive_enabled     = drive_in;
      result.last_fault        = fault_in;
   end

endmodule

>>> src/motor_speed_ramp_sequencer.sv
// Top level of the motor speed ramp sequencer: input stage, result stage and config.
// One command or tick is accepted every cycle unless stalled. A transfer on req is
// written to the input register at the accepting edge (the rpm-to-hertz multiply, 16
// by 24 bits with round to nearest, sits before that register); the sequencer state
// and the result register are updated once the result register is free or read, and
// the result is then offered on rsp. The input and result registers give two places:
// a new item is taken while a finished result waits, and req is held back only
// while both registers are full and the rsp side is stalled. Configuration writes
// take effect on the next edge and are meant to be done while no item is in flight.
module motor_speed_ramp_sequencer
   import msrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   msrs_req_if.sink              req_ch,
   msrs_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   result_type res_ff, result;
   logic       res_valid_ff, res_valid_in;
   logic       advance, take;
   logic [PROD_W:0] prod;

   msrs_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign advance      = item_valid_ff && (!res_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !item_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      prod = (PROD_W+1)'(req_ch.speed_rpm) * (PROD_W+1)'(cfg.rpm_rate) + ROUND_HALF;
      item_in.mode         = mode_type'(req_ch.mode);
      item_in.speed_rpm    = req_ch.speed_rpm;
      item_in.driver_error = req_ch.driver_error;
      item_in.calc_freq    = prod[PROD_W:RATE_FRAC];
      item_valid_in = take || (item_valid_ff && !advance);
      res_valid_in  = advance || (res_valid_ff && !rsp_ch.ready);
   end

   msrs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         res_ff <= result;
      end
   end

   assign rsp_ch.valid             = res_valid_ff;
   assign rsp_ch.reply             = res_ff.reply;
   assign rsp_ch.status            = res_ff.status;
   assign rsp_ch.current_frequency = res_ff.current_frequency;
   assign rsp_ch.target_frequency  = res_ff.target_frequency;
   assign rsp_ch.frequency_written = res_ff.frequency_written;
   assign rsp_ch.pulse_enabled     = res_ff.pulse_enabled;
   assign rsp_ch.drive_enabled     = res_ff.drive_enabled;
   assign rsp_ch.last_fault        = res_ff.last_fault;

endmodule

>>> tb/sv/ramp_check_pkg.sv
// Expected-result tracking for the motor speed ramp sequencer testbench.
`timescale 1ns / 100ps

package ramp_check_pkg;
   import msrs_pkg::*;

   class ramp_tracker;
      logic [FREQ_BITS-1:0] lo_freq, hi_freq;
      logic [RPM_W-1:0]     lo_rpm, hi_rpm;
      logic [STEP_W-1:0]    step;
      logic [RATE_W-1:0]    rate;

      logic [STATUS_W-1:0]  status;
      logic [FREQ_BITS-1:0] now_hz, goal_hz;
      logic                 pulse_on, drive_on;
      logic [ERR_W-1:0]     fault_code;

      result_type           due_results[$];
      int                   mismatches, compared, steps_driven;

      function new();
         lo_freq      = MIN_FREQ_RST;
         hi_freq      = MAX_FREQ_RST;
         lo_rpm       = MIN_RPM_RST;
         hi_rpm       = MAX_RPM_RST;
         step         = STEP_RST;
         rate         = RATE_RST;
         status       = ST_DISABLED;
         now_hz       = '0;
         goal_hz      = MIN_FREQ_RST;
         pulse_on     = 1'b0;
         drive_on     = 1'b0;
         fault_code   = '0;
         mismatches   = 0;
         compared     = 0;
         steps_driven = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_MIN_FREQ: lo_freq = val[FREQ_BITS-1:0];
            CSR_MAX_FREQ: hi_freq = val[FREQ_BITS-1:0];
            CSR_MIN_RPM:  lo_rpm  = val[RPM_W-1:0];
            CSR_MAX_RPM:  hi_rpm  = val[RPM_W-1:0];
            CSR_STEP:     step    = val[STEP_W-1:0];
            CSR_RATE:     rate    = val[RATE_W-1:0];
            default: ;
         endcase
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction

      // true when a tick in the present state would talk to the driver
      function bit drives_hw();
         case (status)
            ST_STARTING:            return 1'b1;
            ST_RUNNING, ST_RAMPING: return now_hz != goal_hz;
            ST_STOPPING:            return pulse_on || drive_on;
            default:                return 1'b0;
         endcase
      endfunction

      function void trip_fault(logic [ERR_W-1:0] code);
         pulse_on   = 1'b0;
         drive_on   = 1'b0;
         fault_code = code;
         status     = ST_FAULT;
      endfunction

      function bit ramp_toward_goal(logic [ERR_W-1:0] code);
         logic [FREQ_BITS-1:0] limit, gap;
         limit = (step == '0) ? FREQ_BITS'(1) : FREQ_BITS'(step);
         if (now_hz == goal_hz) return 1'b0;
         if (code != '0) begin
            trip_fault(code);
            return 1'b0;
         end
         if (now_hz < goal_hz) begin
            gap    = goal_hz - now_hz;
            now_hz = now_hz + ((gap < limit) ? gap : limit);
         end else begin
            gap    = now_hz - goal_hz;
            now_hz = now_hz - ((gap < limit) ? gap : limit);
         end
         return 1'b1;
      endfunction

      function bit advance_tick(logic [ERR_W-1:0] code);
         bit wrote;
         wrote = 1'b0;
         case (status)
            ST_STARTING: begin
               if (code != '0) begin
                  trip_fault(code);
               end else begin
                  now_hz   = lo_freq;
                  pulse_on = 1'b1;
                  drive_on = 1'b1;
                  wrote    = 1'b1;
                  status   = (goal_hz > lo_freq) ? ST_RAMPING : ST_RUNNING;
               end
            end
            ST_STOPPING: begin
               if (!drive_on && !pulse_on) begin
                  now_hz  = '0;
                  goal_hz = lo_freq;
                  status  = ST_DISABLED;
               end else if (now_hz != goal_hz) begin
                  wrote = ramp_toward_goal(code);
               end else if (code != '0) begin
                  trip_fault(code);
               end else begin
                  pulse_on = 1'b0;
                  drive_on = 1'b0;
                  now_hz   = '0;
                  goal_hz  = lo_freq;
                  status   = ST_DISABLED;
               end
            end
            ST_RUNNING, ST_RAMPING: begin
               wrote = ramp_toward_goal(code);
               if (status != ST_FAULT) status = (now_hz == goal_hz) ? ST_RUNNING : ST_RAMPING;
            end
            default: ;
         endcase
         return wrote;
      endfunction

      function logic [REPLY_W-1:0] request_speed(logic [RPM_W-1:0] rpm);
         logic [PROD_W:0]   scaled;
         logic [CALC_W-1:0] hz;
         if (status == ST_STOPPING || status == ST_FAULT) return REPLY_BAD_STATE;
         if (rpm < lo_rpm || rpm > hi_rpm) return REPLY_BAD_ARG;
         scaled = (PROD_W+1)'(rpm) * (PROD_W+1)'(rate) + ROUND_HALF;
         hz     = scaled[PROD_W:RATE_FRAC];
         // range check at full width so an oversized result is refused, not wrapped
         if (hz < lo_freq || hz > hi_freq) return REPLY_BAD_ARG;
         goal_hz = hz[FREQ_BITS-1:0];
         if (status == ST_RUNNING) status = ST_RAMPING;
         return REPLY_OK;
      endfunction

      function void note_item(mode_type mode, logic [RPM_W-1:0] rpm, logic [ERR_W-1:0] code);
         result_type want;
         want = '0;
         case (mode)
            MODE_TICK: want.frequency_written = advance_tick(code);
            MODE_START: begin
               if (status == ST_DISABLED) status = ST_STARTING;
               else if (status == ST_STOPPING || status == ST_FAULT) want.reply = REPLY_BAD_STATE;
            end
            MODE_STOP: begin
               if (status == ST_FAULT) begin
                  want.reply = REPLY_BAD_STATE;
               end else if (status != ST_DISABLED && status != ST_STOPPING) begin
                  goal_hz = lo_freq;
                  status  = ST_STOPPING;
               end
            end
            default: want.reply = request_speed(rpm);
         endcase
         want.status            = status;
         want.current_frequency = now_hz;
         want.target_frequency  = goal_hz;
         want.pulse_enabled     = pulse_on;
         want.drive_enabled     = drive_on;
         want.last_fault        = fault_code;
         if (want.frequency_written) steps_driven++;
         due_results.push_back(want);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 50) $display("error: result %0d: %s", compared, msg);
      endtask

      task check_result(result_type got);
         result_type want;
         if (due_results.size() == 0) begin
            report($sformatf("status %0d arrived with nothing outstanding", got.status));
            return;
         end
         want = due_results.pop_front();
         compared++;
         if (got.reply !== want.reply)
            report($sformatf("reply %0d, expected %0d", got.reply, want.reply));
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.current_frequency !== want.current_frequency)
            report($sformatf("current_frequency %0d, expected %0d",
                             got.current_frequency, want.current_frequency));
         if (got.target_frequency !== want.target_frequency)
            report($sformatf("target_frequency %0d, expected %0d",
                             got.target_frequency, want.target_frequency));
         if (got.frequency_written !== want.frequency_written)
            report($sformatf("frequency_written %0b, expected %0b",
                             got.frequency_written, want.frequency_written));
         if (got.pulse_enabled !== want.pulse_enabled)
            report($sformatf("pulse_enabled %0b, expected %0b",
                             got.pulse_enabled, want.pulse_enabled));
         if (got.drive_enabled !== want.drive_enabled)
            report($sformatf("drive_enabled %0b, expected %0b",
                             got.drive_enabled, want.drive_enabled));
         if (got.last_fault !== want.last_fault)
            report($sformatf("last_fault %0h, expected %0h", got.last_fault, want.last_fault));
      endtask
   endclass

endpackage

>>> tb/sv/tb.sv
// Top-level testbench for the motor speed ramp sequencer.
`timescale 1ns / 100ps

module tb;
   import msrs_pkg::*;
   import ramp_check_pkg::*;

   localparam int NUM_SETTINGS    = 7;
   localparam int WATCHDOG_CYCLES = 3000;
   localparam int HOLD_CYCLES     = 64;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   msrs_req_if req_ch();
   msrs_rsp_if rsp_ch();

   motor_speed_ramp_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ramp_tracker model;
   result_type  seen;
   int          send_idle_pct = 8;
   int          rsp_stall_pct = 49;
   bit          hold_wanted   = 1'b0;
   int          hold_left     = 0;
   int          quiet_cycles  = 0;
   int          items_sent    = 0;

   // min_freq, max_freq, min_rpm, max_rpm, ramp_step, rpm_rate
   cfg_type settings [NUM_SETTINGS] = '{
      '{MIN_FREQ_RST, MAX_FREQ_RST, MIN_RPM_RST, MAX_RPM_RST, STEP_RST, RATE_RST},
      '{20'd0,     20'hFFFFF, 16'd0,    16'hFFFF, 16'hFFFF, 24'hFFFFFF},
      '{20'd1000,  20'd1100,  16'd500,  16'd700,  16'd0,    24'h020000},
      '{20'd5,     20'd40000, 16'd0,    16'hFFFF, 16'd777,  24'h008000},
      '{20'd0,     20'd50,    16'd10,   16'd10,   16'd1,    24'h000000},
      '{20'hFFFFF, 20'd0,     16'hFFFF, 16'd0,    16'h8000, 24'h000100},
      '{MIN_FREQ_RST, MAX_FREQ_RST, MIN_RPM_RST, MAX_RPM_RST, STEP_RST, RATE_RST}
   };
   int burst_len [NUM_SETTINGS] = '{130, 110, 110, 110, 50, 70, 110};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_wanted && hold_left == 0) begin
         hold_left   = HOLD_CYCLES;
         hold_wanted = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen.reply             = rsp_ch.reply;
         seen.status            = rsp_ch.status;
         seen.current_frequency = rsp_ch.current_frequency;
         seen.target_frequency  = rsp_ch.target_frequency;
         seen.frequency_written = rsp_ch.frequency_written;
         seen.pulse_enabled     = rsp_ch.pulse_enabled;
         seen.drive_enabled     = rsp_ch.drive_enabled;
         seen.last_fault        = rsp_ch.last_fault;
         model.check_result(seen);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else if (!reset) begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("timeout: no transfer in %0d cycles", WATCHDOG_CYCLES);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic send_item(mode_type mode, logic [RPM_W-1:0] rpm, logic [ERR_W-1:0] code);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= mode;
      req_ch.speed_rpm    <= rpm;
      req_ch.driver_error <= code;
      do @(posedge clock); while (!req_ch.ready);
      model.note_item(mode, rpm, code);
      items_sent++;
   endtask

   task automatic settle();
      @(negedge clock) req_ch.valid <= 1'b0;
      while (model.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      model.write_reg(idx, val);
   endtask

   task automatic apply_setting(cfg_type c);
      write_csr(CSR_MIN_FREQ, CSR_DATA_W'(c.min_freq));
      write_csr(CSR_MAX_FREQ, CSR_DATA_W'(c.max_freq));
      write_csr(CSR_MIN_RPM,  CSR_DATA_W'(c.min_rpm));
      write_csr(CSR_MAX_RPM,  CSR_DATA_W'(c.max_rpm));
      write_csr(CSR_STEP,     CSR_DATA_W'(c.ramp_step));
      write_csr(CSR_RATE,     CSR_DATA_W'(c.rpm_rate));
      @(negedge clock) csr_we <= 1'b0;
   endtask

   // mostly speeds that land inside the frequency window, plus limits and noise
   function automatic logic [RPM_W-1:0] pick_rpm();
      longint unsigned hz, rpm;
      int              roll;
      roll = $urandom_range(0, 99);
      if (roll < 55 && model.rate != '0) begin
         hz  = $urandom_range(model.hi_freq, model.lo_freq);
         rpm = ((hz << RATE_FRAC) + model.rate / 2) / model.rate;
         return (rpm > 65535) ? '1 : rpm[RPM_W-1:0];
      end
      if (roll < 80) return RPM_W'($urandom_range(model.hi_rpm, model.lo_rpm));
      if (roll < 92) begin
         case ($urandom_range(0, 3))
            0:       return model.lo_rpm - RPM_W'(1);
            1:       return model.hi_rpm + RPM_W'(1);
            2:       return '0;
            default: return '1;
         endcase
      end
      return RPM_W'($urandom_range(0, 65535));
   endfunction

   task automatic random_item(bit may_fault);
      mode_type         mode;
      logic [ERR_W-1:0] code;
      int               roll;
      roll = $urandom_range(0, 99);
      if (model.status == ST_DISABLED && roll < 30) mode = MODE_START;
      else if (roll < 52) mode = MODE_TICK;
      else if (roll < 62) mode = MODE_START;
      else if (roll < 72) mode = MODE_STOP;
      else mode = MODE_SPEED;
      code = ERR_W'($urandom_range(0, 255));
      // fault is permanent, so driver errors only hit live ticks at the very end
      if (mode == MODE_TICK && model.drives_hw() && !(may_fault && $urandom_range(0, 5) == 0))
         code = '0;
      send_item(mode, pick_rpm(), code);
   endtask

   task automatic park();
      int guard;
      guard = 0;
      if (model.status != ST_DISABLED && model.status != ST_FAULT)
         send_item(MODE_STOP, pick_rpm(), ERR_W'($urandom_range(0, 255)));
      while (model.status != ST_DISABLED && model.status != ST_FAULT && guard < 4000) begin
         send_item(MODE_TICK, pick_rpm(),
                   model.drives_hw() ? ERR_W'(0) : ERR_W'($urandom_range(0, 255)));
         guard++;
      end
   endtask

   initial begin
      model               = new();
      req_ch.valid        = 1'b0;
      req_ch.mode         = MODE_TICK;
      req_ch.speed_rpm    = '0;
      req_ch.driver_error = '0;
      rsp_ch.ready        = 1'b0;
      csr_we              = 1'b0;
      csr_index           = CSR_MIN_FREQ;
      csr_wdata           = '0;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      send_item(MODE_TICK,  16'hFFFF, 8'hFF);
      send_item(MODE_SPEED, 16'h0000, 8'h00);
      send_item(MODE_SPEED, 16'hFFFF, 8'h00);
      send_item(MODE_SPEED, 16'd6000, 8'h00);   // stored while disabled
      send_item(MODE_START, 16'd0,    8'hFF);
      send_item(MODE_SPEED, 16'd150,  8'h00);   // stored while starting
      send_item(MODE_STOP,  16'd0,    8'h00);   // outputs still off
      send_item(MODE_SPEED, 16'd1000, 8'h00);
      send_item(MODE_START, 16'd0,    8'h00);
      send_item(MODE_TICK,  16'd0,    8'hFF);   // straight back to disabled
      send_item(MODE_STOP,  16'd0,    8'h00);
      send_item(MODE_START, 16'd0,    8'h00);
      send_item(MODE_TICK,  16'd0,    8'h00);
      send_item(MODE_TICK,  16'd0,    8'h5A);
      send_item(MODE_SPEED, 16'd250,  8'h00);
      send_item(MODE_TICK,  16'd0,    8'h00);
      send_item(MODE_START, 16'd0,    8'h00);
      send_item(MODE_TICK,  16'd0,    8'h00);
      send_item(MODE_SPEED, 16'd100,  8'h00);
      send_item(MODE_TICK,  16'd0,    8'h00);
      send_item(MODE_STOP,  16'd0,    8'h00);
      send_item(MODE_TICK,  16'd0,    8'h00);
      send_item(MODE_SPEED, 16'd3000, 8'h00);
      send_item(MODE_TICK,  16'd0,    8'h00);
      send_item(MODE_TICK,  16'd0,    8'hA5);

      for (int k = 0; k < NUM_SETTINGS; k++) begin
         settle();
         apply_setting(settings[k]);
         send_idle_pct = (k % 3 == 0) ? 8 : (k % 3 == 1) ? 49 : 0;
         rsp_stall_pct = (k % 3 == 0) ? 49 : (k % 3 == 1) ? 8 : 0;
         for (int n = 0; n < burst_len[k]; n++) begin
            if (k == 2 && n == 50) hold_wanted = 1'b1;
            random_item(1'b0);
         end
         park();
      end

      for (int n = 0; n < 600 && model.status != ST_FAULT; n++) random_item(1'b1);
      repeat (24) random_item(1'b1);
      settle();

      $display("%0d items over %0d register settings, %0d results compared",
               items_sent, NUM_SETTINGS, model.compared);
      $display("%0d frequency steps driven; final status %0d, fault code %0h",
               model.steps_driven, model.status, model.fault_code);
      if (model.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> files.f
src/msrs_pkg.sv
src/msrs_if.sv
src/msrs_cfg.sv
src/msrs_core.sv
src/motor_speed_ramp_sequencer.sv
tb/sv/ramp_check_pkg.sv
tb/sv/tb.sv
